### design/dqm_pkg.sv
// Shared types and constants for the deque with middle read.
package dqm_pkg;

    localparam int unsigned DEPTH_DEF = 16;
    localparam int unsigned VALUE_W   = 32;
    localparam int unsigned REQ_W     = 3;
    localparam int unsigned STATUS_W  = 2;

    typedef enum logic [REQ_W-1:0] {
        REQ_PUSH_FRONT = 3'd0,
        REQ_PUSH_BACK  = 3'd1,
        REQ_POP_FRONT  = 3'd2,
        REQ_POP_BACK   = 3'd3,
        REQ_QUERY      = 3'd4
    } t_req;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_READ,
        S_LOAD
    } t_state;

    typedef struct packed {
        logic capture;
        logic exec;
        logic rd;
        logic load;
    } t_cmd;

    typedef struct packed {
        logic out_free;
    } t_sts;

endpackage

### design/dqm_if.sv
// Request and response channel interfaces for the deque with middle read.
interface dqm_req_if;
    import dqm_pkg::*;

    logic                       valid;
    logic                       ready;
    logic        [REQ_W-1:0]    req_type;
    logic signed [VALUE_W-1:0]  item_value;

    modport source (output valid, req_type, item_value, input ready);
    modport sink   (input valid, req_type, item_value, output ready);
endinterface

interface dqm_rsp_if #(
    parameter int unsigned CNT_W = 5
);
    import dqm_pkg::*;

    logic                       valid;
    logic                       ready;
    logic signed [VALUE_W-1:0]  middle_value;
    logic                       is_empty;
    logic        [CNT_W-1:0]    item_count;
    logic        [STATUS_W-1:0] op_status;

    modport source (output valid, middle_value, is_empty, item_count, op_status, input ready);
    modport sink   (input valid, middle_value, is_empty, item_count, op_status, output ready);
endinterface

### design/dqm_ctrl.sv
// Sequencing controller for the deque with middle read.
module dqm_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  dqm_pkg::t_sts i_sts,
    output dqm_pkg::t_cmd o_cmd
);
    import dqm_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_EXEC;
                end
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state    = S_READ;
            end
            S_READ: begin
                o_cmd.rd = 1'b1;
                n_state  = S_LOAD;
            end
            S_LOAD: begin
                // hold until the output register can take the result
                if (i_sts.out_free) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    a_load_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LOAD) && !i_sts.out_free |=> (r_state == S_LOAD))
        else $error("controller left load while output was busy");

    a_exec_after_capture: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.capture |=> (r_state == S_EXEC))
        else $error("capture not followed by execute");

    a_one_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(o_cmd))
        else $error("more than one command issued");

endmodule

### design/dqm_dpath.sv
// Datapath: ring store, front pointer, count and result register.
module dqm_dpath #(
    parameter int unsigned DEPTH = dqm_pkg::DEPTH_DEF,
    parameter int unsigned CNT_W = $clog2(DEPTH + 1)
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  dqm_pkg::t_cmd                      i_cmd,
    output dqm_pkg::t_sts                      o_sts,
    input  logic        [dqm_pkg::REQ_W-1:0]   i_req_type,
    input  logic signed [dqm_pkg::VALUE_W-1:0] i_item_value,
    input  logic                               i_out_ready,
    output logic                               o_out_valid,
    output logic signed [dqm_pkg::VALUE_W-1:0] o_middle_value,
    output logic                               o_is_empty,
    output logic        [CNT_W-1:0]            o_item_count,
    output logic        [dqm_pkg::STATUS_W-1:0] o_op_status
);
    import dqm_pkg::*;

    localparam int unsigned ADDR_W = $clog2(DEPTH);
    localparam int unsigned SUM_W  = ADDR_W + 1;

    logic signed [VALUE_W-1:0] mem [DEPTH];

    logic        [REQ_W-1:0]   r_req;
    logic signed [VALUE_W-1:0] r_value;
    logic        [ADDR_W-1:0]  r_front;
    logic        [ADDR_W-1:0]  n_front;
    logic        [CNT_W-1:0]   r_count;
    logic        [CNT_W-1:0]   n_count;
    t_status                   r_status;
    t_status                   n_status;
    logic signed [VALUE_W-1:0] r_rd_data;
    logic                      r_out_valid;
    logic signed [VALUE_W-1:0] r_out_middle;
    logic                      r_out_empty;
    logic        [CNT_W-1:0]   r_out_count;
    t_status                   r_out_status;

    logic                      wr_en;
    logic        [ADDR_W-1:0]  wr_addr;
    logic        [ADDR_W-1:0]  rd_addr;
    logic                      is_full;
    logic                      is_zero;

    function automatic logic [ADDR_W-1:0] ring_add(input logic [ADDR_W-1:0] a,
                                                   input logic [ADDR_W-1:0] b);
        logic [SUM_W-1:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= SUM_W'(DEPTH)) begin
            s = s - SUM_W'(DEPTH);
        end
        return s[ADDR_W-1:0];
    endfunction

    assign is_full = (r_count == CNT_W'(DEPTH));
    assign is_zero = (r_count == '0);

    // request decode and pointer update
    always_comb begin
        n_front  = r_front;
        n_count  = r_count;
        n_status = ST_DONE;
        wr_en    = 1'b0;
        wr_addr  = ring_add(r_front, ADDR_W'(r_count));
        unique case (r_req)
            REQ_PUSH_FRONT: begin
                if (is_full) begin
                    n_status = ST_FULL;
                end else begin
                    n_front = (r_front == '0) ? ADDR_W'(DEPTH - 1) : r_front - ADDR_W'(1);
                    wr_addr = n_front;
                    wr_en   = 1'b1;
                    n_count = r_count + CNT_W'(1);
                end
            end
            REQ_PUSH_BACK: begin
                if (is_full) begin
                    n_status = ST_FULL;
                end else begin
                    wr_en   = 1'b1;
                    n_count = r_count + CNT_W'(1);
                end
            end
            REQ_POP_FRONT: begin
                if (is_zero) begin
                    n_status = ST_EMPTY;
                end else begin
                    n_front = ring_add(r_front, ADDR_W'(1));
                    n_count = r_count - CNT_W'(1);
                end
            end
            REQ_POP_BACK: begin
                if (is_zero) begin
                    n_status = ST_EMPTY;
                end else begin
                    n_count = r_count - CNT_W'(1);
                end
            end
            default: begin
                n_status = ST_DONE;
            end
        endcase
    end

    assign rd_addr = ring_add(r_front, ADDR_W'(r_count >> 1));

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_req   <= i_req_type;
            r_value <= i_item_value;
        end
        if (i_cmd.exec) begin
            r_status <= n_status;
        end
        if (i_cmd.exec && wr_en) begin
            mem[wr_addr] <= r_value;
        end
        if (i_cmd.rd) begin
            r_rd_data <= mem[rd_addr];
        end
        if (i_cmd.load) begin
            r_out_middle <= is_zero ? '0 : r_rd_data;
            r_out_empty  <= is_zero;
            r_out_count  <= r_count;
            r_out_status <= r_status;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front     <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.exec) begin
                r_front <= n_front;
                r_count <= n_count;
            end
            if (i_cmd.load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_sts.out_free = !r_out_valid || i_out_ready;
    assign o_out_valid    = r_out_valid;
    assign o_middle_value = r_out_middle;
    assign o_is_empty     = r_out_empty;
    assign o_item_count   = r_out_count;
    assign o_op_status    = r_out_status;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("element count above depth");

    a_front_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        SUM_W'(r_front) < SUM_W'(DEPTH))
        else $error("front pointer out of range");

    a_reject_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.exec && (n_status != ST_DONE) |=> $stable(r_count) && $stable(r_front))
        else $error("rejected request changed the queue");

endmodule

### design/deque_with_middle_read.sv
// Top level of the bounded deque that reports its middle element.
// Usage:
//   i_req carries one request: req_type (push front, push back, pop front,
//   pop back, query; unused codes act as query) and item_value for pushes.
//   o_rsp returns one response per request: the element at index count/2
//   from the front after the request (0 when empty), the empty flag, the
//   element count and a status (done, push rejected full, pop ignored empty).
//   Both channels move a request or response when valid and ready are high.
// Timing:
//   The response turns valid after the request is accepted, through three steps:
//   pointer/count update with the store write, registered store read at the
//   middle position, load into the response register (held while that register
//   is still busy). No new request is taken until these steps are done and the
//   controller is back in idle; i_req.ready is high only while it waits in idle.
// Reset:
//   Synchronous, active low. Clears the front pointer, the count and the
//   response valid; store contents stay undefined and never reach the response unwritten.
// Stalls:
//   A waiting response does not block the next request; a second response
//   holds in the load step until the response register drains.
module deque_with_middle_read #(
    parameter int unsigned DEPTH = dqm_pkg::DEPTH_DEF,
    parameter int unsigned CNT_W = $clog2(DEPTH + 1)
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    dqm_req_if.sink    i_req,
    dqm_rsp_if.source  o_rsp
);
    import dqm_pkg::*;

    t_cmd cmd;
    t_sts sts;

    // sequence each request through update, read and load
    dqm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .o_in_ready (i_req.ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // ring store, pointers and response register
    dqm_dpath #(
        .DEPTH (DEPTH),
        .CNT_W (CNT_W)
    ) u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .i_req_type     (i_req.req_type),
        .i_item_value   (i_req.item_value),
        .i_out_ready    (o_rsp.ready),
        .o_out_valid    (o_rsp.valid),
        .o_middle_value (o_rsp.middle_value),
        .o_is_empty     (o_rsp.is_empty),
        .o_item_count   (o_rsp.item_count),
        .o_op_status    (o_rsp.op_status)
    );

    a_empty_matches_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid |-> (o_rsp.is_empty == (o_rsp.item_count == '0)))
        else $error("empty flag disagrees with count");

    a_empty_middle_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid && o_rsp.is_empty |-> (o_rsp.middle_value == '0))
        else $error("nonzero middle value on empty queue");

    a_no_accept_while_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.valid && i_req.ready |=> !i_req.ready)
        else $error("request accepted while previous one in flight");

endmodule
